### sv/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define QPRQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define QPRQ_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define QPRQ_ASSERT(lbl, prop)

`define QPRQ_ASSERT_NEVER(lbl, cond)

`endif

`endif

### sv/qprq_pkg.sv
package qprq_pkg;

  localparam int DataW = 32;
  localparam int ProdW = 2 * DataW;
  localparam int AccW  = ProdW + 2;
  localparam int StepW = 4;
  localparam int CfgIdxW = 3;

  localparam logic [StepW-1:0] STEP_IDLE  = 4'd0;
  localparam logic [StepW-1:0] STEP_FIRST = 4'd1;
  localparam logic [StepW-1:0] STEP_LAST  = 4'd13;

  localparam logic [CfgIdxW-1:0] CFG_B0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_A1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_A2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KP = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KR = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_G  = 3'd5;

  localparam logic signed [DataW-1:0] KP_RESET = 32'sd5033165;
  localparam logic signed [DataW-1:0] KR_RESET = 32'sd335544320;

  typedef enum logic [2:0] {
    MA_B0, MA_A1, MA_A2, MA_KP, MA_KR, MA_U, MA_U1
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_E, MB_E2, MB_Y1, MB_Y2, MB_Y, MB_G
  } mul_b_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LOADQ
  } acc_op_e;

  typedef enum logic [1:0] {
    WR_NONE, WR_Y, WR_U, WR_Q
  } wr_e;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT
  } jmp_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc;
    logic    sh24;
  } mac_ctrl_t;

  typedef struct packed {
    mul_a_e    ma;
    mul_b_e    mb;
    mac_ctrl_t mac;
    wr_e       wr;
    jmp_e      jmp;
  } ucode_t;

  function automatic ucode_t uc(input mul_a_e ma, input mul_b_e mb, input logic mul_en,
                                input acc_op_e acc, input logic sh24, input wr_e wr,
                                input jmp_e jmp);
    ucode_t w;
    w.ma         = ma;
    w.mb         = mb;
    w.mac.mul_en = mul_en;
    w.mac.acc    = acc;
    w.mac.sh24   = sh24;
    w.wr         = wr;
    w.jmp        = jmp;
    return w;
  endfunction

  // y: b0*e - b0*e2 - a1*y1 - a2*y2 (Q2.30)
  // u: kp*e + kr*y (Q8.24)
  // q: q1<<30 + u*g + u1*g (Q2.30)
  function automatic ucode_t ucode(input logic [StepW-1:0] s);
    ucode_t w;
    case (s)
      4'd0:    w = uc(MA_B0, MB_E,  1'b0, ACC_HOLD,  1'b0, WR_NONE, JMP_WAIT_IN);
      4'd1:    w = uc(MA_B0, MB_E,  1'b1, ACC_HOLD,  1'b0, WR_NONE, JMP_NEXT);
      4'd2:    w = uc(MA_B0, MB_E2, 1'b1, ACC_LOAD,  1'b0, WR_NONE, JMP_NEXT);
      4'd3:    w = uc(MA_A1, MB_Y1, 1'b1, ACC_SUB,   1'b0, WR_NONE, JMP_NEXT);
      4'd4:    w = uc(MA_A2, MB_Y2, 1'b1, ACC_SUB,   1'b0, WR_NONE, JMP_NEXT);
      4'd5:    w = uc(MA_A2, MB_Y2, 1'b0, ACC_SUB,   1'b0, WR_NONE, JMP_NEXT);
      4'd6:    w = uc(MA_KP, MB_E,  1'b1, ACC_HOLD,  1'b0, WR_Y,    JMP_NEXT);
      4'd7:    w = uc(MA_KR, MB_Y,  1'b1, ACC_LOAD,  1'b1, WR_NONE, JMP_NEXT);
      4'd8:    w = uc(MA_KR, MB_Y,  1'b0, ACC_ADD,   1'b1, WR_NONE, JMP_NEXT);
      4'd9:    w = uc(MA_KR, MB_Y,  1'b0, ACC_HOLD,  1'b1, WR_U,    JMP_NEXT);
      4'd10:   w = uc(MA_U,  MB_G,  1'b1, ACC_LOADQ, 1'b0, WR_NONE, JMP_NEXT);
      4'd11:   w = uc(MA_U1, MB_G,  1'b1, ACC_ADD,   1'b0, WR_NONE, JMP_NEXT);
      4'd12:   w = uc(MA_U1, MB_G,  1'b0, ACC_ADD,   1'b0, WR_NONE, JMP_NEXT);
      4'd13:   w = uc(MA_U1, MB_G,  1'b0, ACC_HOLD,  1'b0, WR_Q,    JMP_WAIT_OUT);
      default: w = uc(MA_B0, MB_E,  1'b0, ACC_HOLD,  1'b0, WR_NONE, JMP_WAIT_OUT);
    endcase
    return w;
  endfunction

endpackage

### sv/qprq_mac.sv
module qprq_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qprq_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [qprq_pkg::DataW-1:0] op_a_i,
  input  logic signed [qprq_pkg::DataW-1:0] op_b_i,
  input  logic signed [qprq_pkg::DataW-1:0] quad_prev_i,
  output logic signed [qprq_pkg::DataW-1:0] res_o
);
  import qprq_pkg::*;

  localparam int ShW = AccW - 24;

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  acc_d, acc_q;
  logic signed [AccW-1:0]  prod_ext, half, qterm;
  logic signed [ShW-1:0]   shifted;

  assign prod_d = op_a_i * op_b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctrl_i.mul_en) begin
        prod_q <= prod_d;
      end
      acc_q <= acc_d;
    end
  end

  always_comb begin
    prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    half     = ctrl_i.sh24 ? (AccW'(1) <<< 23) : (AccW'(1) <<< 29);
    qterm    = {{(AccW-DataW-30){quad_prev_i[DataW-1]}}, quad_prev_i, 30'd0};
    case (ctrl_i.acc)
      ACC_LOAD:  acc_d = prod_ext + half;
      ACC_ADD:   acc_d = acc_q + prod_ext;
      ACC_SUB:   acc_d = acc_q - prod_ext;
      ACC_LOADQ: acc_d = qterm + half;
      default:   acc_d = acc_q;
    endcase
  end

  // rounding half was added at load, so the floor shift rounds half up
  always_comb begin
    if (ctrl_i.sh24) begin
      shifted = acc_q[AccW-1:24];
    end else begin
      shifted = {{6{acc_q[AccW-1]}}, acc_q[AccW-1:30]};
    end
    if (shifted > ShW'(64'sd2147483647)) begin
      res_o = 32'sh7fffffff;
    end else if (shifted < -ShW'(64'sd2147483648)) begin
      res_o = 32'sh80000000;
    end else begin
      res_o = shifted[DataW-1:0];
    end
  end

endmodule

### sv/quasi_pr_controller_with_quadrature.sv
// Quasi-PR controller with quadrature output. Each error item yields one result
// item (drive u, quadrature q). A 14-step microcode program runs one shared
// signed 32x32 multiplier and a 66-bit accumulator: one idle step waits for an
// item, then 13 steps compute y, u and q. A new item is accepted only in the idle
// step, after the final step is left. The final step holds while the output
// register still carries an untaken result.
`include "assert_macros.svh"

module quasi_pr_controller_with_quadrature (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qprq_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [qprq_pkg::DataW-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [qprq_pkg::DataW-1:0]   error_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [qprq_pkg::DataW-1:0]   drive_out_o,
  output logic signed [qprq_pkg::DataW-1:0]   quadrature_out_o
);
  import qprq_pkg::*;

  logic signed [DataW-1:0] b0_q, a1_q, a2_q, kp_q, kr_q, g_q;
  logic signed [DataW-1:0] e_q, e1_q, e2_q, y1_q, y2_q, u1_q, q1_q;
  logic signed [DataW-1:0] y_q, u_q;
  logic signed [DataW-1:0] out_drive_q, out_quad_q;
  logic                    out_valid_q;
  logic [StepW-1:0]        step_d, step_q;

  ucode_t                  cur;
  logic                    in_acc, out_free, adv_last;
  logic signed [DataW-1:0] op_a, op_b, res;

  assign cur         = ucode(step_q);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (cur.jmp != JMP_WAIT_IN);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv_last    = (cur.jmp == JMP_WAIT_OUT) && out_free;

  assign out_valid_o      = out_valid_q;
  assign drive_out_o      = out_drive_q;
  assign quadrature_out_o = out_quad_q;

  always_comb begin
    case (cur.jmp)
      JMP_WAIT_IN:  step_d = in_acc ? step_q + 4'd1 : step_q;
      JMP_WAIT_OUT: step_d = out_free ? STEP_IDLE : step_q;
      default:      step_d = step_q + 4'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
      kp_q <= KP_RESET;
      kr_q <= KR_RESET;
      g_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_B0:  b0_q <= cfg_data_i;
        CFG_A1:  a1_q <= cfg_data_i;
        CFG_A2:  a2_q <= cfg_data_i;
        CFG_KP:  kp_q <= cfg_data_i;
        CFG_KR:  kr_q <= cfg_data_i;
        CFG_G:   g_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cur.ma)
      MA_B0:   op_a = b0_q;
      MA_A1:   op_a = a1_q;
      MA_A2:   op_a = a2_q;
      MA_KP:   op_a = kp_q;
      MA_KR:   op_a = kr_q;
      MA_U:    op_a = u_q;
      MA_U1:   op_a = u1_q;
      default: op_a = '0;
    endcase
    case (cur.mb)
      MB_E:    op_b = e_q;
      MB_E2:   op_b = e2_q;
      MB_Y1:   op_b = y1_q;
      MB_Y2:   op_b = y2_q;
      MB_Y:    op_b = y_q;
      MB_G:    op_b = g_q;
      default: op_b = '0;
    endcase
  end

  qprq_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (cur.mac),
    .op_a_i      (op_a),
    .op_b_i      (op_b),
    .quad_prev_i (q1_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q <= error_in_i;
    end
    if (cur.wr == WR_Y) begin
      y_q <= res;
    end
    if (cur.wr == WR_U) begin
      u_q <= res;
    end
    if (adv_last) begin
      out_drive_q <= u_q;
      out_quad_q  <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q        <= '0;
      e2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      u1_q        <= '0;
      q1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_last) begin
        e2_q        <= e1_q;
        e1_q        <= e_q;
        y2_q        <= y1_q;
        y1_q        <= y_q;
        u1_q        <= u_q;
        q1_q        <= res;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `QPRQ_ASSERT_NEVER(a_step_range, step_q > STEP_LAST)
  `QPRQ_ASSERT(a_out_from_last, $rose(out_valid_o) |-> $past(step_q) == STEP_LAST)
  `QPRQ_ASSERT(a_accept_starts, (in_valid_i && !in_stall_o) |=> step_q == STEP_FIRST)

endmodule
